>>> design/x86alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86alu_pkg
// shared types, operation codes and helpers of the x86 integer alu
// ----------------------------------------------------------------------------
package x86alu_pkg;

    localparam int FUNC_W = 4;
    localparam int SIZE_W = 2;
    localparam int DATA_W = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_SHL = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_SHR = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_AND = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_XOR = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_OR  = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_NOT = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_NEG = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_INC = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_DEC = 4'd10;

    // operand size codes
    localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 2'd2;

    // datapath operation after decode
    typedef enum logic [2:0] {
        K_SHL,
        K_SHR,
        K_AND,
        K_XOR,
        K_OR,
        K_NOT,
        K_ADD,
        K_SUB
    } t_kind;

    function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic top_bit(input logic [DATA_W-1:0] v,
                                     input logic [SIZE_W-1:0] size);
        logic t;
        case (size)
            SIZE_BYTE: t = v[7];
            SIZE_WORD: t = v[15];
            default:   t = v[31];
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

>>> design/x86alu_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// x86alu_in_if / x86alu_out_if
// valid/ready channels carrying alu operations and alu results
// ----------------------------------------------------------------------------
interface x86alu_in_if;
    logic                             valid;
    logic                             ready;
    logic [x86alu_pkg::FUNC_W-1:0]    func;
    logic [x86alu_pkg::SIZE_W-1:0]    op_size;
    logic [x86alu_pkg::DATA_W-1:0]    operand_a;
    logic [x86alu_pkg::DATA_W-1:0]    operand_b;

    modport source (output valid, func, op_size, operand_a, operand_b, input ready);
    modport sink   (input valid, func, op_size, operand_a, operand_b, output ready);
endinterface

interface x86alu_out_if;
    logic                             valid;
    logic                             ready;
    logic [x86alu_pkg::DATA_W-1:0]    value;
    logic                             ok;
    logic                             carry_flag;
    logic                             parity_flag;
    logic                             aux_carry_flag;
    logic                             zero_flag;
    logic                             sign_flag;
    logic                             overflow_flag;

    modport source (output valid, value, ok, carry_flag, parity_flag, aux_carry_flag,
                    zero_flag, sign_flag, overflow_flag, input ready);
    modport sink   (input valid, value, ok, carry_flag, parity_flag, aux_carry_flag,
                    zero_flag, sign_flag, overflow_flag, output ready);
endinterface
`default_nettype wire

>>> design/x86_integer_alu_with_flags_top.sv
`timescale 1ns / 1ps
`default_nettype none
// pipeline: an accepted transaction passes the stage 1, stage 2 and stage 3 registers to o_out
// throughput: one transaction per cycle while o_out is ready, set by the three-stage pipeline
//   (decode, execute, flag generation); each stage holds when its successor is full
// reset: i_rst_n synchronous, active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_top
// x86 integer alu (shifts, logic, add/sub family) with CF PF AF ZF SF OF
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    x86alu_in_if.sink          i_in,
    x86alu_out_if.source       o_out
);
    import x86alu_pkg::*;

    // ------------------------------------------------------------------
    // stage handshake: a stage loads when empty or when its content moves on
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3     = !r_v3 || o_out.ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign i_in.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: decode, mask operands to the size, map neg/inc/dec onto add/sub
    // ------------------------------------------------------------------
    t_kind               n_kind1,  r_kind1;
    logic [DATA_W-1:0]   n_x1,     r_x1;
    logic [DATA_W-1:0]   n_y1,     r_y1;
    logic [DATA_W-1:0]   r_raw1;
    logic [SIZE_W-1:0]   r_size1;
    logic                n_ok1,    r_ok1;
    logic                n_fen1,   r_fen1;   // flags are produced
    logic                n_cfen1,  r_cfen1;  // carry is produced

    always_comb begin
        logic [DATA_W-1:0] a_m;
        logic [DATA_W-1:0] b_m;
        logic              cnt_zero;
        a_m      = i_in.operand_a & size_mask(i_in.op_size);
        b_m      = i_in.operand_b & size_mask(i_in.op_size);
        cnt_zero = (b_m[4:0] == 5'd0);
        n_ok1    = (i_in.func <= FUNC_DEC) && (i_in.op_size <= SIZE_DWORD);
        n_x1     = a_m;
        n_y1     = b_m;
        n_fen1   = 1'b1;
        n_cfen1  = 1'b1;
        case (i_in.func)
            FUNC_SHL: begin
                n_kind1 = K_SHL;
                n_fen1  = !cnt_zero;
            end
            FUNC_SHR: begin
                n_kind1 = K_SHR;
                n_fen1  = !cnt_zero;
            end
            FUNC_AND: n_kind1 = K_AND;
            FUNC_XOR: n_kind1 = K_XOR;
            FUNC_OR:  n_kind1 = K_OR;
            FUNC_NOT: begin
                n_kind1 = K_NOT;
                n_fen1  = 1'b0;
            end
            FUNC_NEG: begin
                // neg is 0 - a: borrow, aux borrow and overflow all match x86
                n_kind1 = K_SUB;
                n_x1    = '0;
                n_y1    = a_m;
            end
            FUNC_SUB: n_kind1 = K_SUB;
            FUNC_ADD: n_kind1 = K_ADD;
            FUNC_INC: begin
                n_kind1 = K_ADD;
                n_y1    = {{(DATA_W-1){1'b0}}, 1'b1};
                n_cfen1 = 1'b0;
            end
            FUNC_DEC: begin
                n_kind1 = K_SUB;
                n_y1    = {{(DATA_W-1){1'b0}}, 1'b1};
                n_cfen1 = 1'b0;
            end
            default: begin
                n_kind1 = K_NOT;
                n_fen1  = 1'b0;
            end
        endcase
        if (!n_ok1) n_fen1 = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in.valid) begin
            r_kind1 <= n_kind1;
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_raw1  <= i_in.operand_a;
            r_size1 <= i_in.op_size;
            r_ok1   <= n_ok1;
            r_fen1  <= n_fen1;
            r_cfen1 <= n_cfen1;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: execute - barrel shifter, 33-bit adder/subtractor, logic
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]   n_r2,    r_r2;
    logic                n_cf2,   r_cf2;
    logic                n_af2,   r_af2;
    t_kind               r_kind2;
    logic                r_xt2, r_yt2;
    logic                r_cnt1_2;
    logic [SIZE_W-1:0]   r_size2;
    logic                r_ok2, r_fen2;

    always_comb begin
        logic [DATA_W-1:0]   mask;
        logic [4:0]          cnt;
        logic                in_range;
        logic [2*DATA_W-1:0] shl_v;
        logic [DATA_W:0]     shr_v;
        logic [DATA_W:0]     sum;
        logic [DATA_W:0]     diff;
        logic                carry_w;
        mask  = size_mask(r_size1);
        cnt   = r_y1[4:0];
        shl_v = {{DATA_W{1'b0}}, r_x1} << cnt;
        shr_v = {r_x1, 1'b0} >> cnt;
        sum   = {1'b0, r_x1} + {1'b0, r_y1};
        diff  = {1'b0, r_x1} - {1'b0, r_y1};
        case (r_size1)
            SIZE_BYTE: in_range = (cnt[4:3] == 2'b00);
            SIZE_WORD: in_range = !cnt[4];
            default:   in_range = 1'b1;
        endcase
        n_r2    = '0;
        n_cf2   = 1'b0;
        n_af2   = 1'b0;
        carry_w = 1'b0;
        case (r_kind1)
            K_SHL: begin
                case (r_size1)
                    SIZE_BYTE: carry_w = shl_v[8];
                    SIZE_WORD: carry_w = shl_v[16];
                    default:   carry_w = shl_v[32];
                endcase
                n_r2  = shl_v[DATA_W-1:0] & mask;
                n_cf2 = in_range && carry_w;
            end
            K_SHR: begin
                n_r2  = shr_v[DATA_W:1];
                n_cf2 = in_range && shr_v[0];
            end
            K_AND: n_r2 = r_x1 & r_y1;
            K_XOR: n_r2 = r_x1 ^ r_y1;
            K_OR:  n_r2 = r_x1 | r_y1;
            K_NOT: n_r2 = ~r_x1 & mask;
            K_ADD: begin
                case (r_size1)
                    SIZE_BYTE: carry_w = sum[8];
                    SIZE_WORD: carry_w = sum[16];
                    default:   carry_w = sum[32];
                endcase
                n_r2  = sum[DATA_W-1:0] & mask;
                n_cf2 = r_cfen1 && carry_w;
                n_af2 = r_x1[4] ^ r_y1[4] ^ sum[4];
            end
            K_SUB: begin
                // bit w of the difference is the borrow
                case (r_size1)
                    SIZE_BYTE: carry_w = diff[8];
                    SIZE_WORD: carry_w = diff[16];
                    default:   carry_w = diff[32];
                endcase
                n_r2  = diff[DATA_W-1:0] & mask;
                n_cf2 = r_cfen1 && carry_w;
                n_af2 = r_x1[4] ^ r_y1[4] ^ diff[4];
            end
            default: n_r2 = '0;
        endcase
        // unsupported transactions pass operand_a through untouched
        if (!r_ok1) n_r2 = r_raw1;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_r2     <= n_r2;
            r_cf2    <= n_cf2;
            r_af2    <= n_af2;
            r_kind2  <= r_kind1;
            r_xt2    <= top_bit(r_x1, r_size1);
            r_yt2    <= top_bit(r_y1, r_size1);
            r_cnt1_2 <= (r_y1[4:0] == 5'd1);
            r_size2  <= r_size1;
            r_ok2    <= r_ok1;
            r_fen2   <= r_fen1;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: flags from the result, output register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] r_value3;
    logic              r_ok3, r_cf3, r_pf3, r_af3, r_zf3, r_sf3, r_of3;
    logic              n_of3;
    logic              w_rt;

    assign w_rt = top_bit(r_r2, r_size2);

    always_comb begin
        case (r_kind2)
            K_SHL:   n_of3 = r_cnt1_2 && (w_rt ^ r_cf2);
            K_SHR:   n_of3 = r_cnt1_2 && r_xt2;
            K_ADD:   n_of3 = !(r_xt2 ^ r_yt2) && (r_xt2 ^ w_rt);
            K_SUB:   n_of3 = (r_xt2 ^ r_yt2) && (r_xt2 ^ w_rt);
            default: n_of3 = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_value3 <= r_r2;
            r_ok3    <= r_ok2;
            r_cf3    <= r_fen2 && r_cf2;
            r_pf3    <= r_fen2 && !(^r_r2[7:0]);
            r_af3    <= r_fen2 && r_af2;
            r_zf3    <= r_fen2 && (r_r2 == '0);
            r_sf3    <= r_fen2 && w_rt;
            r_of3    <= r_fen2 && n_of3;
        end
    end

    assign o_out.valid          = r_v3;
    assign o_out.value          = r_value3;
    assign o_out.ok             = r_ok3;
    assign o_out.carry_flag     = r_cf3;
    assign o_out.parity_flag    = r_pf3;
    assign o_out.aux_carry_flag = r_af3;
    assign o_out.zero_flag      = r_zf3;
    assign o_out.sign_flag      = r_sf3;
    assign o_out.overflow_flag  = r_of3;

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the x86 integer alu: directed corner operations,
// then random operations under changing back-pressure, with every result
// compared field by field against an in-bench prediction of value and flags
// ----------------------------------------------------------------------------
module tb;
    import x86alu_pkg::*;

    // codes the block must reject
    localparam logic [FUNC_W-1:0] FUNC_BAD_LO = 4'd11;
    localparam logic [FUNC_W-1:0] FUNC_BAD_HI = 4'd15;
    localparam logic [SIZE_W-1:0] SIZE_BAD    = 2'd3;

    localparam int STALL_LIMIT  = 4000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES  = 60;     // long receiver hold-off
    localparam int RANDOM_ITEMS = 240;    // per idling phase

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ok;
        logic              carry;
        logic              parity;
        logic              aux_carry;
        logic              zero;
        logic              sign;
        logic              overflow;
    } t_alu_result;

    // scoreboard: predicts value and flags of each accepted operation and
    // checks results in order
    class alu_scoreboard;
        t_alu_result pending_results[$];
        int unsigned mismatches = 0;

        function void queue_op_result(logic [FUNC_W-1:0] func, logic [SIZE_W-1:0] size,
                                      logic [DATA_W-1:0] a_in, logic [DATA_W-1:0] b_in);
            t_alu_result       r;
            int unsigned       w;
            logic [DATA_W-1:0] mask, top, a, b, res;
            logic [DATA_W:0]   wide;
            logic [4:0]        cnt;
            logic              cf, af, ovf, flags;
            r = '0;
            // rejected operation: operand a passes through, flags all clear
            if (func > FUNC_DEC || size > SIZE_DWORD) begin
                r.value = a_in;
                pending_results.push_back(r);
                return;
            end
            w     = 8 << size;
            mask  = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
            top   = 32'h1 << (w - 1);
            a     = a_in & mask;
            b     = b_in & mask;
            cnt   = b[4:0];
            cf    = 1'b0;
            af    = 1'b0;
            ovf   = 1'b0;
            flags = 1'b1;
            res   = '0;
            case (func)
                FUNC_SHL: begin
                    if (cnt == 0) begin
                        res   = a;
                        flags = 1'b0;
                    end else begin
                        res = (a << cnt) & mask;
                        if (cnt < w)
                            cf = a[w - cnt];
                        if (cnt == 1)
                            ovf = (|(res & top)) ^ cf;
                    end
                end
                FUNC_SHR: begin
                    if (cnt == 0) begin
                        res   = a;
                        flags = 1'b0;
                    end else begin
                        res = (cnt < w) ? (a >> cnt) : '0;
                        if (cnt < w)
                            cf = a[cnt - 1];
                        if (cnt == 1)
                            ovf = |(a & top);
                    end
                end
                FUNC_AND: res = a & b;
                FUNC_XOR: res = a ^ b;
                FUNC_OR:  res = a | b;
                FUNC_NOT: begin
                    res   = ~a & mask;
                    flags = 1'b0;
                end
                FUNC_NEG: begin
                    res = (32'h0 - a) & mask;
                    cf  = (a != 0);
                    af  = (a[3:0] != 0);
                    ovf = (a == top);
                end
                FUNC_SUB, FUNC_DEC: begin
                    if (func == FUNC_DEC)
                        b = 32'h1;
                    res = (a - b) & mask;
                    cf  = (func == FUNC_SUB) && (a < b);
                    af  = a[4] ^ b[4] ^ res[4];
                    ovf = |((a ^ b) & (a ^ res) & top);
                end
                default: begin
                    // add and inc
                    if (func == FUNC_INC)
                        b = 32'h1;
                    wide = {1'b0, a} + {1'b0, b};
                    res  = wide[DATA_W-1:0] & mask;
                    cf   = (func == FUNC_ADD) && ((wide >> w) != 0);
                    af   = a[4] ^ b[4] ^ res[4];
                    ovf  = |(~(a ^ b) & (a ^ res) & top);
                end
            endcase
            r.value = res;
            r.ok    = 1'b1;
            if (flags) begin
                r.carry     = cf;
                r.parity    = ~^res[7:0];
                r.aux_carry = af;
                r.zero      = (res == 0);
                r.sign      = |(res & top);
                r.overflow  = ovf;
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_bit(string name, logic want, logic got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_alu_result got);
            t_alu_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual value %h",
                         $time, got.value);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("value", want.value, got.value);
            compare_bit("ok", want.ok, got.ok);
            compare_bit("cf", want.carry, got.carry);
            compare_bit("pf", want.parity, got.parity);
            compare_bit("af", want.aux_carry, got.aux_carry);
            compare_bit("zf", want.zero, got.zero);
            compare_bit("sf", want.sign, got.sign);
            compare_bit("of", want.overflow, got.overflow);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    x86alu_in_if  in_if ();
    x86alu_out_if out_if ();

    x86_integer_alu_with_flags_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    alu_scoreboard sb = new();

    // idling percentages per cycle, changed by phase
    int unsigned tx_idle_pct = 6;
    int unsigned rx_idle_pct = 76;
    bit          hold_req    = 1'b0;   // asks the receiver for one long hold-off

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // result side: check each accepted transaction, then pick the next ready
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        t_alu_result got;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.value     = out_if.value;
                got.ok        = out_if.ok;
                got.carry     = out_if.carry_flag;
                got.parity    = out_if.parity_flag;
                got.aux_carry = out_if.aux_carry_flag;
                got.zero      = out_if.zero_flag;
                got.sign      = out_if.sign_flag;
                got.overflow  = out_if.overflow_flag;
                sb.check_result(got);
            end
            // a long hold-off lets the pipeline fill and push back on the input
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results still pending", $time,
                         sb.pending_results.size());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // operation side
    // ------------------------------------------------------------------------

    // offer one operation, with random idle cycles ahead of it, and record it
    // once the block takes it
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic [SIZE_W-1:0] size,
                           input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.func      <= func;
        in_if.op_size   <= size;
        in_if.operand_a <= a;
        in_if.operand_b <= b;
        do @(posedge i_clk); while (!in_if.ready);
        sb.queue_op_result(func, size, a, b);
    endtask

    // operand values biased toward sign and carry boundaries
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'h1;
            2:       return '1;
            3:       return 32'h1 << $urandom_range(31);
            4:       return ~(32'h1 << $urandom_range(31));
            5:       return (32'h1 << $urandom_range(31)) - 32'h1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_op();
        logic [FUNC_W-1:0] func;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] a, b;
        // mostly legal codes, a few rejected ones
        if ($urandom_range(99) < 8)
            func = FUNC_W'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        else
            func = FUNC_W'($urandom_range(FUNC_DEC));
        size = ($urandom_range(99) < 5) ? SIZE_BAD : SIZE_W'($urandom_range(SIZE_DWORD));
        a    = pick_operand();
        b    = pick_operand();
        // shift counts spread over all 32 masked values, upper bits random
        if ((func == FUNC_SHL || func == FUNC_SHR) && $urandom_range(1))
            b = ($urandom & 32'hFFFF_FFE0) | $urandom_range(31);
        send_op(func, size, a, b);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.func      <= '0;
        in_if.op_size   <= '0;
        in_if.operand_a <= '0;
        in_if.operand_b <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_op(FUNC_SHL, SIZE_BYTE,  32'h0000_00FF, 32'h0000_0000);  // zero count
        send_op(FUNC_SHL, SIZE_BYTE,  32'hFFFF_FF81, 32'hFFFF_FF01);  // count one
        send_op(FUNC_SHR, SIZE_WORD,  32'h0000_8001, 32'h0000_0001);  // count one
        send_op(FUNC_SHL, SIZE_BYTE,  32'h0000_00FF, 32'h0000_0009);  // count past width
        send_op(FUNC_SHR, SIZE_WORD,  32'h0000_FFFF, 32'h0000_0014);  // count past width
        send_op(FUNC_SHL, SIZE_DWORD, 32'hFFFF_FFFF, 32'h0000_001F);
        send_op(FUNC_SHR, SIZE_DWORD, 32'h8000_0000, 32'hFFFF_FFFF);  // count masked to 31
        send_op(FUNC_AND, SIZE_DWORD, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(FUNC_XOR, SIZE_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_OR,  SIZE_BYTE,  32'hFFFF_FF00, 32'h0000_0000);
        send_op(FUNC_NOT, SIZE_WORD,  32'h1234_5678, 32'hFFFF_FFFF);
        send_op(FUNC_NEG, SIZE_BYTE,  32'h0000_0080, 32'h0000_0000);  // most negative
        send_op(FUNC_NEG, SIZE_DWORD, 32'h0000_0000, 32'h0000_0000);  // zero operand
        send_op(FUNC_NEG, SIZE_WORD,  32'h0000_0001, 32'h0000_0000);
        send_op(FUNC_SUB, SIZE_BYTE,  32'h0000_0000, 32'h0000_0001);  // borrow
        send_op(FUNC_SUB, SIZE_DWORD, 32'h8000_0000, 32'h0000_0001);  // signed overflow
        send_op(FUNC_ADD, SIZE_DWORD, 32'hFFFF_FFFF, 32'h0000_0001);  // carry out
        send_op(FUNC_ADD, SIZE_BYTE,  32'h0000_007F, 32'h0000_0001);  // signed overflow
        send_op(FUNC_INC, SIZE_WORD,  32'h0000_7FFF, 32'hFFFF_FFFF);
        send_op(FUNC_DEC, SIZE_BYTE,  32'h0000_0000, 32'h0000_0000);
        send_op(FUNC_DEC, SIZE_DWORD, 32'h8000_0000, 32'h0000_0000);
        send_op(FUNC_BAD_LO, SIZE_BYTE,  32'hDEAD_BEEF, 32'h0000_0001);  // rejected op
        send_op(FUNC_BAD_HI, SIZE_DWORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(FUNC_ADD, SIZE_BAD, 32'h1234_5678, 32'h0000_0001);       // rejected size
        send_op(FUNC_SHR, SIZE_BAD, 32'hFFFF_FFFF, 32'h0000_0001);

        // phase one: sender mostly busy, receiver mostly stalled
        repeat (RANDOM_ITEMS / 2) send_random_op();

        // long receiver hold-off while operations keep coming back to back
        tx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (30) send_random_op();
        tx_idle_pct = 6;

        // sender pause until the pipeline is empty
        drain_results();
        repeat (RANDOM_ITEMS / 2) send_random_op();

        // phase two: sender mostly idle, receiver mostly ready
        tx_idle_pct = 76;
        rx_idle_pct = 6;
        repeat (RANDOM_ITEMS) send_random_op();

        // phase three: full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_ITEMS) send_random_op();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
